// ----- rtl/tbcfr_pkg.sv -----
// Shared types and constants for the two-bit clocked frame receiver.
`timescale 1ns / 1ps

package tbcfr_pkg;

   localparam int CHAN_W = 4;
   localparam int BYTE_W = 8;
   localparam int LIMIT_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // channel word bit positions
   localparam int CLK_BIT = 3;
   localparam int ACK_BIT = 2;

   // control bytes
   localparam logic [BYTE_W-1:0] CTRL_ESCAPE = 8'h01;
   localparam logic [BYTE_W-1:0] CTRL_BEGIN = 8'h02;
   localparam logic [BYTE_W-1:0] CTRL_END = 8'h03;

   localparam logic [LIMIT_W-1:0] ACK_HOLD_RESET = 8'd20;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_out;
      logic              byte_valid;
      logic [BYTE_W-1:0] byte_value;
      logic              frame_end;
   } result_type;

endpackage

// ----- rtl/tbcfr_core.sv -----
// Frame state machine: clock edge detect, pair shifter, escape and ack handling.
`timescale 1ns / 1ps

module tbcfr_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [tbcfr_pkg::CHAN_W-1:0]        chan,
   input  logic [tbcfr_pkg::LIMIT_W-1:0]       limit,
   output tbcfr_pkg::result_type               result
);

   localparam logic [1:0] PH_AWAIT = 2'd0;
   localparam logic [1:0] PH_RECEIVE = 2'd1;
   localparam logic [1:0] PH_ACK = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [tbcfr_pkg::BYTE_W-1:0] shift_ff, shift_in;
   logic [2:0] bits_ff, bits_in;
   logic prev_clk_ff, prev_clk_in;
   logic escape_ff, escape_in;
   logic [tbcfr_pkg::LIMIT_W-1:0] count_ff, count_in;

   logic clk_edge;
   logic byte_done;
   logic [tbcfr_pkg::BYTE_W-1:0] new_byte;
   logic is_ctrl;

   assign clk_edge = chan[tbcfr_pkg::CLK_BIT] != prev_clk_ff;
   assign new_byte = {shift_ff[tbcfr_pkg::BYTE_W-3:0], chan[1:0]};
   assign byte_done = clk_edge && (bits_ff == 3'd6);
   assign is_ctrl = (new_byte == tbcfr_pkg::CTRL_ESCAPE) ||
                    (new_byte == tbcfr_pkg::CTRL_BEGIN) ||
                    (new_byte == tbcfr_pkg::CTRL_END);

   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      bits_in = bits_ff;
      prev_clk_in = prev_clk_ff;
      escape_in = escape_ff;
      count_in = count_ff;
      result.channel_out = chan;
      result.byte_valid = 1'b0;
      result.byte_value = '0;
      result.frame_end = 1'b0;

      // clock is only tracked while waiting or receiving
      if ((phase_ff == PH_AWAIT || phase_ff == PH_RECEIVE) && clk_edge) begin
         prev_clk_in = chan[tbcfr_pkg::CLK_BIT];
         shift_in = new_byte;
         bits_in = bits_ff + 3'd2;
      end

      case (phase_ff)
         PH_AWAIT: begin
            if (byte_done && new_byte == tbcfr_pkg::CTRL_BEGIN) begin
               phase_in = PH_RECEIVE;
            end
         end
         PH_RECEIVE: begin
            if (byte_done) begin
               result.byte_valid = 1'b1;
               result.byte_value = new_byte;
               if (is_ctrl) begin
                  if (escape_ff) begin
                     escape_in = 1'b0;
                  end else if (new_byte == tbcfr_pkg::CTRL_ESCAPE) begin
                     escape_in = 1'b1;
                  end else if (new_byte == tbcfr_pkg::CTRL_END) begin
                     result.frame_end = 1'b1;
                     phase_in = PH_ACK;
                  end
               end
            end
         end
         PH_ACK: begin
            if (count_ff <= limit) begin
               result.channel_out[tbcfr_pkg::ACK_BIT] = 1'b1;
               if (count_ff == limit) begin
                  count_in = '0;
                  phase_in = PH_RELEASE;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               // limit lowered under a running count: release now
               result.channel_out[tbcfr_pkg::ACK_BIT] = 1'b0;
               count_in = '0;
               phase_in = PH_AWAIT;
            end
         end
         default: begin
            result.channel_out[tbcfr_pkg::ACK_BIT] = 1'b0;
            count_in = '0;
            phase_in = PH_AWAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_AWAIT;
         shift_ff <= '0;
         bits_ff <= '0;
         prev_clk_ff <= 1'b0;
         escape_ff <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff <= bits_in;
         prev_clk_ff <= prev_clk_in;
         escape_ff <= escape_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/two_bit_clocked_frame_receiver.sv -----
// Top level: input register, frame state machine, output register, csr.
// An accepted item is held in the input register; its result is then registered in the
// output register and offered on the result port.
// Throughput: one item per cycle; the input and output registers stall
// together only when the result side holds off.
// Reset (synchronous, active high): waits for BEGIN, shifter and ack count
// cleared, ack hold limit back to 20.
`timescale 1ns / 1ps

module two_bit_clocked_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tbcfr_pkg::REQ_DATA_W-1:0]     req_tdata,   // [3:0] channel_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tbcfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [3:0] channel_out, [11:4] byte_value
   output logic                                 rsp_tuser,   // [0] byte_valid
   output logic                                 rsp_tlast,   // frame_end
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbcfr_pkg::LIMIT_W-1:0]        csr_data
);

   logic in_valid_ff;
   logic [tbcfr_pkg::CHAN_W-1:0] in_chan_ff;
   logic out_valid_ff;
   tbcfr_pkg::result_type out_ff;
   tbcfr_pkg::result_type core_result;
   logic [tbcfr_pkg::LIMIT_W-1:0] limit_ff;
   logic advance;
   logic step;

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step = in_valid_ff && advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tbcfr_pkg::ACK_HOLD_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_chan_ff <= req_tdata[tbcfr_pkg::CHAN_W-1:0];
      end
   end

   tbcfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .chan   (in_chan_ff),
      .limit  (limit_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {4'b0000, out_ff.byte_value, out_ff.channel_out};
   assign rsp_tuser = out_ff.byte_valid;
   assign rsp_tlast = out_ff.frame_end;

endmodule

// ----- rtl/tbcfr_checker.sv -----
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps

module tbcfr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tbcfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   // frame end only comes with a completed byte
   a_end_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end without byte");

   // frame end byte is the END code
   a_end_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[11:4] == tbcfr_pkg::CTRL_END)
      else $error("frame end on non-END byte");

   // no byte, zero value
   a_idle_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[11:4] == 8'h00)
      else $error("byte value without byte");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled item changed");

endmodule

bind two_bit_clocked_frame_receiver tbcfr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/sv/two_bit_clocked_frame_receiver_test.sv -----
// Testbench for the two-bit clocked frame receiver: directed and random frames, self-checking.
`timescale 1ns / 1ps

module two_bit_clocked_frame_receiver_test;

   localparam int RUN_LIMIT = 600000;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef enum logic [1:0] {
      IDLE_WAIT   = 2'd0,
      RECEIVING   = 2'd1,
      ACK_DRIVE   = 2'd2,
      ACK_RELEASE = 2'd3
   } rx_phase_type;

   class frame_rx_scoreboard;
      logic [tbcfr_pkg::LIMIT_W-1:0] hold_limit;
      rx_phase_type                  phase;
      logic [tbcfr_pkg::BYTE_W-1:0]  shifter;
      logic [2:0]                    bits_held;
      logic                          seen_clock;
      logic                          escape_pending;
      logic [tbcfr_pkg::LIMIT_W-1:0] ack_count;
      tbcfr_pkg::result_type         awaited_results[$];
      int errors, words_in, results_seen, frames_closed, bytes_passed;
      int escaped_ctrl, early_releases;

      function new();
         hold_limit = tbcfr_pkg::ACK_HOLD_RESET;
         phase = IDLE_WAIT;
         shifter = '0;
         bits_held = '0;
         seen_clock = 1'b0;
         escape_pending = 1'b0;
         ack_count = '0;
         errors = 0;
         words_in = 0;
         results_seen = 0;
         frames_closed = 0;
         bytes_passed = 0;
         escaped_ctrl = 0;
         early_releases = 0;
      endfunction

      // true when a clock change completes a byte
      function bit shift_pair(input logic [tbcfr_pkg::CHAN_W-1:0] ch);
         if (ch[tbcfr_pkg::CLK_BIT] == seen_clock) return 1'b0;
         seen_clock = ch[tbcfr_pkg::CLK_BIT];
         shifter = {shifter[tbcfr_pkg::BYTE_W-3:0], ch[1:0]};
         bits_held = bits_held + 3'd2;
         return bits_held == 3'd0;
      endfunction

      function tbcfr_pkg::result_type frame_result(input logic [tbcfr_pkg::CHAN_W-1:0] ch);
         tbcfr_pkg::result_type r;
         r = '0;
         r.channel_out = ch;
         case (phase)
            IDLE_WAIT: begin
               if (shift_pair(ch) && shifter == tbcfr_pkg::CTRL_BEGIN) phase = RECEIVING;
            end
            RECEIVING: begin
               if (shift_pair(ch)) begin
                  r.byte_valid = 1'b1;
                  r.byte_value = shifter;
                  bytes_passed++;
                  if (shifter == tbcfr_pkg::CTRL_ESCAPE || shifter == tbcfr_pkg::CTRL_BEGIN ||
                      shifter == tbcfr_pkg::CTRL_END) begin
                     if (escape_pending) begin
                        escape_pending = 1'b0;
                        escaped_ctrl++;
                     end else if (shifter == tbcfr_pkg::CTRL_ESCAPE) begin
                        escape_pending = 1'b1;
                     end else if (shifter == tbcfr_pkg::CTRL_END) begin
                        r.frame_end = 1'b1;
                        phase = ACK_DRIVE;
                        frames_closed++;
                     end
                  end
               end
            end
            default: begin
               if (phase == ACK_DRIVE && ack_count <= hold_limit) begin
                  r.channel_out[tbcfr_pkg::ACK_BIT] = 1'b1;
                  if (ack_count == hold_limit) begin
                     ack_count = '0;
                     phase = ACK_RELEASE;
                  end else begin
                     ack_count = ack_count + 1'b1;
                  end
               end else begin
                  // count above a lowered limit releases at once; the release phase also returns to waiting here
                  if (phase == ACK_DRIVE) early_releases++;
                  r.channel_out[tbcfr_pkg::ACK_BIT] = 1'b0;
                  ack_count = '0;
                  phase = IDLE_WAIT;
               end
            end
         endcase
         return r;
      endfunction

      function void note_channel_word(input logic [tbcfr_pkg::CHAN_W-1:0] ch);
         awaited_results.insert(awaited_results.size(), frame_result(ch));
         words_in++;
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 40) $display("mismatch: %s", msg);
      endtask

      task check_result(input tbcfr_pkg::result_type got);
         tbcfr_pkg::result_type exp;
         if (awaited_results.size() == 0) begin
            report("result arrived with none expected");
            return;
         end
         exp = awaited_results.pop_front();
         results_seen++;
         if (got.channel_out !== exp.channel_out)
            report($sformatf("result %0d channel_out %h, expected %h",
                             results_seen, got.channel_out, exp.channel_out));
         if (got.byte_valid !== exp.byte_valid)
            report($sformatf("result %0d byte_valid %b, expected %b",
                             results_seen, got.byte_valid, exp.byte_valid));
         if (got.byte_value !== exp.byte_value)
            report($sformatf("result %0d byte_value %h, expected %h",
                             results_seen, got.byte_value, exp.byte_value));
         if (got.frame_end !== exp.frame_end)
            report($sformatf("result %0d frame_end %b, expected %b",
                             results_seen, got.frame_end, exp.frame_end));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tbcfr_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [3:0] channel_in
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tbcfr_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [3:0] channel_out, [11:4] byte_value
   logic                             rsp_tuser;  // [0] byte_valid
   logic                             rsp_tlast;  // frame_end
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tbcfr_pkg::LIMIT_W-1:0]    csr_data = '0;

   frame_rx_scoreboard sb;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   int cycles = 0;
   int input_stalls = 0;
   int limit_writes = 0;

   two_bit_clocked_frame_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) input_stalls++;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tdata[3:0], rsp_tuser, rsp_tdata[11:4], rsp_tlast});
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      int gap;
      int taken;
      bit held_off;
      taken = 0;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = recv_gaps ? $urandom_range(0, 19) : 0;
         if (!held_off && taken >= 700) begin
            held_off = 1'b1;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   task automatic send_tick(input logic [tbcfr_pkg::CHAN_W-1:0] ch);
      int gap;
      gap = send_gaps ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(tbcfr_pkg::REQ_DATA_W-tbcfr_pkg::CHAN_W){1'b0}}, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_channel_word(ch);
   endtask

   // clock level flips, so the pair is shifted in
   task automatic send_pair(input logic [1:0] data, input logic ack);
      send_tick({~sb.seen_clock, ack, data});
   endtask

   task automatic send_byte(input logic [tbcfr_pkg::BYTE_W-1:0] b, input logic ack,
                            input bit jitter);
      logic [tbcfr_pkg::CHAN_W-1:0] w;
      for (int i = 3; i >= 0; i--) begin
         if (jitter && $urandom_range(0, 6) == 0) begin
            // clock held: nothing shifts
            w = 4'($urandom_range(0, 15));
            w[tbcfr_pkg::CLK_BIT] = sb.seen_clock;
            send_tick(w);
         end
         w = 4'($urandom_range(0, 15));
         send_pair(b[2*i +: 2], jitter ? w[tbcfr_pkg::ACK_BIT] : ack);
      end
   endtask

   task automatic send_frame();
      int n;
      logic [tbcfr_pkg::BYTE_W-1:0] b;
      logic [tbcfr_pkg::CHAN_W-1:0] w;
      while (sb.phase == ACK_DRIVE || sb.phase == ACK_RELEASE) begin
         w = 4'($urandom_range(0, 15));
         send_tick(w);
      end
      while (sb.phase == IDLE_WAIT && sb.bits_held != 3'd0) begin
         w = 4'($urandom_range(0, 15));
         send_pair(w[1:0], w[tbcfr_pkg::ACK_BIT]);
      end
      send_byte(tbcfr_pkg::CTRL_BEGIN, 1'b0, 1'b1);
      n = $urandom_range(0, 8);
      repeat (n) begin
         if ($urandom_range(0, 99) < 35) b = 8'($urandom_range(1, 3));
         else b = 8'($urandom_range(0, 255));
         send_byte(b, 1'b0, 1'b1);
      end
      if ($urandom_range(0, 9) != 0) send_byte(tbcfr_pkg::CTRL_END, 1'b0, 1'b1);
   endtask

   task automatic send_noise(input int n);
      logic [tbcfr_pkg::CHAN_W-1:0] w;
      repeat (n) begin
         w = 4'($urandom_range(0, 15));
         send_tick(w);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [tbcfr_pkg::LIMIT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.hold_limit = v;
      limit_writes++;
   endtask

   initial begin
      logic [tbcfr_pkg::LIMIT_W-1:0] limits [6];
      int phase_end;
      sb = new();
      limits[0] = 8'd255;
      limits[1] = 8'd0;
      limits[2] = 8'd1;
      limits[3] = 8'($urandom_range(2, 253));
      limits[4] = 8'd20;
      limits[5] = 8'd254;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: short ack, escaped END, all-ones byte, limit lowered mid-ack
      write_limit(8'd2);
      send_tick(4'h7);
      send_byte(tbcfr_pkg::CTRL_BEGIN, 1'b0, 1'b0);
      send_byte(tbcfr_pkg::CTRL_ESCAPE, 1'b1, 1'b0);
      send_byte(tbcfr_pkg::CTRL_END, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(tbcfr_pkg::CTRL_END, 1'b0, 1'b0);
      send_tick(4'hF);
      send_tick(4'h0);
      drain();
      write_limit(8'd0);
      send_tick(4'hF);
      send_tick(4'h8);

      for (int p = 0; p < 6; p++) begin
         drain();
         write_limit(limits[p]);
         send_gaps = (p % 3 != 1);
         recv_gaps = (p % 3 != 2);
         phase_end = 25 + (p + 1) * 305;
         while (sb.words_in < phase_end) begin
            if ($urandom_range(0, 99) < 85) send_frame();
            else send_noise($urandom_range(5, 30));
         end
      end
      drain();

      $display("run: %0d channel words, %0d results, %0d frames closed, %0d bytes passed",
               sb.words_in, sb.results_seen, sb.frames_closed, sb.bytes_passed);
      $display("     %0d escaped control bytes, %0d early ack releases,",
               sb.escaped_ctrl, sb.early_releases);
      $display("     %0d stalled input cycles, %0d limit writes",
               input_stalls, limit_writes);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
